### src/eight_bit_cpu_alu_with_flags_macros.svh
// Assertion macros used by the ALU top-level RTL file.
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted.
`define SM83_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that also holds during reset.
`define SM83_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SM83_ASSERT(lbl, clk, rstn, prop, msg)
`define SM83_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### src/sm83_alu_pkg.sv
// Types, opcode codes and constants for the SM83 ALU.
package sm83_alu_pkg;

  // Flag bit positions within the 4-bit flag nibble
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // Unprefixed single-byte opcodes
  localparam logic [7:0] OPC_RLCA = 8'h07;
  localparam logic [7:0] OPC_RRCA = 8'h0f;
  localparam logic [7:0] OPC_RLA  = 8'h17;
  localparam logic [7:0] OPC_RRA  = 8'h1f;
  localparam logic [7:0] OPC_DAA  = 8'h27;
  localparam logic [7:0] OPC_CPL  = 8'h2f;
  localparam logic [7:0] OPC_SCF  = 8'h37;
  localparam logic [7:0] OPC_CCF  = 8'h3f;

  // Opcode group masks and matches
  localparam logic [7:0] GRP_MASK_HI  = 8'hc0;
  localparam logic [7:0] GRP_ALU_REG  = 8'h80;
  localparam logic [7:0] GRP_MASK_ROW = 8'hc7;
  localparam logic [7:0] GRP_ALU_IMM  = 8'hc6;
  localparam logic [7:0] GRP_INC_R8   = 8'h04;
  localparam logic [7:0] GRP_DEC_R8   = 8'h05;

  // DAA adjustment constants
  localparam logic [7:0] DAA_ADJ_HI = 8'h60;
  localparam logic [7:0] DAA_ADJ_LO = 8'h06;
  localparam logic [7:0] DAA_MAX_HI = 8'h99;
  localparam logic [3:0] DAA_MAX_LO = 4'h9;
  localparam logic [3:0] NIBBLE_MAX = 4'hf;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_ADC = 3'd1,
    ALU_SUB = 3'd2,
    ALU_SBC = 3'd3,
    ALU_AND = 3'd4,
    ALU_XOR = 3'd5,
    ALU_OR  = 3'd6,
    ALU_CP  = 3'd7
  } alu_op_e;

  typedef enum logic [1:0] {
    CB_SHIFT = 2'd0,
    CB_BIT   = 2'd1,
    CB_RES   = 2'd2,
    CB_SET   = 2'd3
  } cb_grp_e;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } cb_shift_e;

  typedef struct packed {
    logic       prefixed;
    logic [7:0] opcode;
    logic [7:0] acc_in;
    logic [7:0] source_in;
    logic [3:0] flags_in;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_enable;
    logic       recognized;
  } alu_rsp_t;

endpackage

### src/sm83_alu_core.sv
// Combinational decode and datapath of the SM83 ALU.
module sm83_alu_core (
  input  sm83_alu_pkg::alu_req_t req_i,
  output sm83_alu_pkg::alu_rsp_t rsp_o
);
  import sm83_alu_pkg::*;

  logic [7:0] a;
  logic [7:0] s;
  logic [3:0] fin;
  logic       cin;
  logic       c_use;
  logic [8:0] add_sum;
  logic [4:0] add_half;
  logic [8:0] sub_diff;
  logic [4:0] sub_half;
  logic [7:0] bit_mask;
  logic [7:0] r;
  logic [3:0] fl;
  logic       we;
  logic       rec;
  logic       cout;
  logic       daa_c;
  alu_op_e    op;

  assign a   = req_i.acc_in;
  assign s   = req_i.source_in;
  assign fin = req_i.flags_in;
  assign cin = fin[FlagC];
  assign op  = alu_op_e'(req_i.opcode[5:3]);

  // Carry in only for ADC and SBC
  assign c_use    = (op == ALU_ADC || op == ALU_SBC) ? cin : 1'b0;
  assign add_sum  = {1'b0, a} + {1'b0, s} + {8'd0, c_use};
  assign add_half = {1'b0, a[3:0]} + {1'b0, s[3:0]} + {4'd0, c_use};
  assign sub_diff = {1'b0, a} - {1'b0, s} - {8'd0, c_use};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, s[3:0]} - {4'd0, c_use};
  assign bit_mask = 8'd1 << req_i.opcode[5:3];

  always_comb begin
    r     = 8'd0;
    fl    = fin;
    we    = 1'b0;
    rec   = 1'b1;
    cout  = 1'b0;
    daa_c = cin;
    if (req_i.prefixed) begin
      we = 1'b1;
      unique case (cb_grp_e'(req_i.opcode[7:6]))
        CB_BIT: begin
          r  = s;
          we = 1'b0;
          fl = {~|(s & bit_mask), 1'b0, 1'b1, cin};
        end
        CB_RES: r = s & ~bit_mask;
        CB_SET: r = s | bit_mask;
        CB_SHIFT: begin
          unique case (cb_shift_e'(req_i.opcode[5:3]))
            SH_RLC:  begin cout = s[7]; r = {s[6:0], s[7]}; end
            SH_RRC:  begin cout = s[0]; r = {s[0], s[7:1]}; end
            SH_RL:   begin cout = s[7]; r = {s[6:0], cin};  end
            SH_RR:   begin cout = s[0]; r = {cin, s[7:1]};  end
            SH_SLA:  begin cout = s[7]; r = {s[6:0], 1'b0}; end
            SH_SRA:  begin cout = s[0]; r = {s[7], s[7:1]}; end
            SH_SWAP: begin cout = 1'b0; r = {s[3:0], s[7:4]}; end
            SH_SRL:  begin cout = s[0]; r = {1'b0, s[7:1]}; end
            default: begin cout = 1'b0; r = s; end
          endcase
          fl = {~|r, 1'b0, 1'b0, cout};
        end
        default: r = s;
      endcase
    end else if ((req_i.opcode & GRP_MASK_HI) == GRP_ALU_REG ||
                 (req_i.opcode & GRP_MASK_ROW) == GRP_ALU_IMM) begin
      we = 1'b1;
      unique case (op)
        ALU_ADD, ALU_ADC: begin
          r  = add_sum[7:0];
          fl = {~|add_sum[7:0], 1'b0, add_half[4], add_sum[8]};
        end
        ALU_SUB, ALU_SBC: begin
          r  = sub_diff[7:0];
          fl = {~|sub_diff[7:0], 1'b1, sub_half[4], sub_diff[8]};
        end
        ALU_CP: begin
          // Flags of the subtraction, accumulator kept
          r  = a;
          we = 1'b0;
          fl = {~|sub_diff[7:0], 1'b1, sub_half[4], sub_diff[8]};
        end
        ALU_AND: begin r = a & s; fl = {~|(a & s), 1'b0, 1'b1, 1'b0}; end
        ALU_XOR: begin r = a ^ s; fl = {~|(a ^ s), 1'b0, 1'b0, 1'b0}; end
        ALU_OR:  begin r = a | s; fl = {~|(a | s), 1'b0, 1'b0, 1'b0}; end
        default: r = a;
      endcase
    end else if ((req_i.opcode & GRP_MASK_ROW) == GRP_INC_R8) begin
      we = 1'b1;
      r  = s + 8'd1;
      fl = {~|r, 1'b0, s[3:0] == NIBBLE_MAX, cin};
    end else if ((req_i.opcode & GRP_MASK_ROW) == GRP_DEC_R8) begin
      we = 1'b1;
      r  = s - 8'd1;
      fl = {~|r, 1'b1, s[3:0] == 4'd0, cin};
    end else begin
      we = 1'b1;
      unique case (req_i.opcode)
        OPC_RLCA: begin r = {a[6:0], a[7]}; fl = {3'd0, a[7]}; end
        OPC_RRCA: begin r = {a[0], a[7:1]}; fl = {3'd0, a[0]}; end
        OPC_RLA:  begin r = {a[6:0], cin};  fl = {3'd0, a[7]}; end
        OPC_RRA:  begin r = {cin, a[7:1]};  fl = {3'd0, a[0]}; end
        OPC_DAA: begin
          r = a;
          if (fin[FlagN]) begin
            if (cin) r = r - DAA_ADJ_HI;
            if (fin[FlagH]) r = r - DAA_ADJ_LO;
          end else begin
            if (cin || a > DAA_MAX_HI) begin
              r     = r + DAA_ADJ_HI;
              daa_c = 1'b1;
            end
            if (fin[FlagH] || a[3:0] > DAA_MAX_LO) r = r + DAA_ADJ_LO;
          end
          fl = {~|r, fin[FlagN], 1'b0, daa_c};
        end
        OPC_CPL: begin r = ~a; fl = {fin[FlagZ], 1'b1, 1'b1, cin}; end
        OPC_SCF: begin r = a;  fl = {fin[FlagZ], 1'b0, 1'b0, 1'b1}; end
        OPC_CCF: begin r = a;  fl = {fin[FlagZ], 1'b0, 1'b0, ~cin}; end
        default: begin
          r   = 8'd0;
          fl  = fin;
          we  = 1'b0;
          rec = 1'b0;
        end
      endcase
    end
  end

  assign rsp_o.result       = r;
  assign rsp_o.flags_out    = fl;
  assign rsp_o.write_enable = we;
  assign rsp_o.recognized   = rec;

endmodule

### src/eight_bit_cpu_alu_with_flags.sv
// Top level of the SM83 ALU: input register, datapath, result register.
//
//   channel | direction  | handshake               | payload
//   --------+------------+-------------------------+---------------------------------------------
//   in      | to block   | in_valid_i/in_ready_o   | prefixed, opcode, acc_in, source_in, flags_in
//   out     | from block | out_valid_o/out_ready_i | result, flags_out, write_enable, recognized
//
// Each transaction passes the input register, one level of ALU logic and the
// result register; one transaction per cycle is sustained while out_ready_i stays high.
// Throughput holds because each stage reloads at every edge at which the stage after it frees.
// Reset clears both stage valid bits; payload registers are not reset.
// An output stall holds the result register; the input register keeps filling
// until it is also full, so in_ready_o drops only when both stages hold data.
`include "eight_bit_cpu_alu_with_flags_macros.svh"

module eight_bit_cpu_alu_with_flags (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       prefixed_i,
  input  logic [7:0] opcode_i,
  input  logic [7:0] acc_in_i,
  input  logic [7:0] source_in_i,
  input  logic [3:0] flags_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] result_o,
  output logic [3:0] flags_out_o,
  output logic       write_enable_o,
  output logic       recognized_o
);
  import sm83_alu_pkg::*;

  logic     req_valid_q;
  alu_req_t req_q;
  logic     rsp_valid_q;
  alu_rsp_t rsp_q;
  alu_rsp_t rsp_d;
  logic     req_advance;
  logic     in_fire;

  // Result register frees when empty or when its transaction leaves
  assign req_advance = ~rsp_valid_q | out_ready_i;
  assign in_ready_o  = ~req_valid_q | req_advance;
  assign in_fire     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= '{prefixed:  prefixed_i,
                 opcode:    opcode_i,
                 acc_in:    acc_in_i,
                 source_in: source_in_i,
                 flags_in:  flags_in_i};
    end
  end

  sm83_alu_core u_core (
    .req_i (req_q),
    .rsp_o (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_advance) begin
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_advance && req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o    = rsp_valid_q;
  assign result_o       = rsp_q.result;
  assign flags_out_o    = rsp_q.flags_out;
  assign write_enable_o = rsp_q.write_enable;
  assign recognized_o   = rsp_q.recognized;

  `SM83_ASSERT(a_ready_when_out_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with empty result register")
  `SM83_ASSERT(a_accept_fills_stage, clk_i, rst_ni, in_fire |=> req_valid_q, "accepted transaction lost at input register")
  `SM83_ASSERT(a_unrecognized_inert, clk_i, rst_ni, (out_valid_o && !recognized_o) |-> (!write_enable_o && result_o == 8'd0), "unrecognized opcode writes a result")
  `SM83_ASSERT_ALWAYS(a_reset_clears_valid, clk_i, !rst_ni |=> (!req_valid_q && !rsp_valid_q), "stage valid set during reset")

endmodule

### dv/tb_top.sv
// Self-checking testbench for the SM83 ALU: directed cases, random traffic, stalls.
`timescale 1ns / 100ps

module tb_top;
  import sm83_alu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [7:0]  OPC_NOP     = 8'h00;
  localparam logic [3:0]  F_Z         = 4'(1 << FlagZ);
  localparam logic [3:0]  F_N         = 4'(1 << FlagN);
  localparam logic [3:0]  F_H         = 4'(1 << FlagH);
  localparam logic [3:0]  F_C         = 4'(1 << FlagC);

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       prefixed = 1'b0;
  logic [7:0] opcode = '0;
  logic [7:0] acc_in = '0;
  logic [7:0] source_in = '0;
  logic [3:0] flags_in = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] result;
  logic [3:0] flags_out;
  logic       write_enable;
  logic       recognized;

  alu_rsp_t   expected_q[$];
  int         err_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         stall_cycles = 0;

  eight_bit_cpu_alu_with_flags u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .prefixed_i    (prefixed),
    .opcode_i      (opcode),
    .acc_in_i      (acc_in),
    .source_in_i   (source_in),
    .flags_in_i    (flags_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_o      (result),
    .flags_out_o   (flags_out),
    .write_enable_o(write_enable),
    .recognized_o  (recognized)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
    logic [3:0] f;
    f = '0;
    f[FlagZ] = z;
    f[FlagN] = n;
    f[FlagH] = h;
    f[FlagC] = c;
    return f;
  endfunction

  // Expected ALU outcome for one operation; the block keeps no state.
  function automatic alu_rsp_t predict_alu(alu_req_t q);
    alu_rsp_t   rsp;
    alu_op_e    op;
    logic [8:0] wide;
    logic [4:0] nib;
    logic [7:0] a, s, r;
    logic [2:0] idx;
    logic       cin, c, cout;
    a = q.acc_in;
    s = q.source_in;
    cin = q.flags_in[FlagC];
    rsp.result = '0;
    rsp.flags_out = q.flags_in;
    rsp.write_enable = 1'b1;
    rsp.recognized = 1'b1;
    if (q.prefixed) begin
      idx = q.opcode[5:3];
      case (cb_grp_e'(q.opcode[7:6]))
        CB_BIT: begin
          rsp.result = s;
          rsp.write_enable = 1'b0;
          rsp.flags_out = pack_flags(~s[idx], 1'b0, 1'b1, cin);
        end
        CB_RES: rsp.result = s & ~(8'h01 << idx);
        CB_SET: rsp.result = s | (8'h01 << idx);
        default: begin
          case (cb_shift_e'(idx))
            SH_RLC:  begin cout = s[7]; r = {s[6:0], s[7]}; end
            SH_RRC:  begin cout = s[0]; r = {s[0], s[7:1]}; end
            SH_RL:   begin cout = s[7]; r = {s[6:0], cin}; end
            SH_RR:   begin cout = s[0]; r = {cin, s[7:1]}; end
            SH_SLA:  begin cout = s[7]; r = {s[6:0], 1'b0}; end
            SH_SRA:  begin cout = s[0]; r = {s[7], s[7:1]}; end
            SH_SWAP: begin cout = 1'b0; r = {s[3:0], s[7:4]}; end
            default: begin cout = s[0]; r = {1'b0, s[7:1]}; end
          endcase
          rsp.result = r;
          rsp.flags_out = pack_flags(r == 8'h00, 1'b0, 1'b0, cout);
        end
      endcase
    end else if ((q.opcode & GRP_MASK_HI) == GRP_ALU_REG
                 || (q.opcode & GRP_MASK_ROW) == GRP_ALU_IMM) begin
      op = alu_op_e'(q.opcode[5:3]);
      c = (op == ALU_ADC || op == ALU_SBC) ? cin : 1'b0;
      case (op)
        ALU_ADD, ALU_ADC: begin
          wide = {1'b0, a} + {1'b0, s} + {8'b0, c};
          nib = {1'b0, a[3:0]} + {1'b0, s[3:0]} + {4'b0, c};
          r = wide[7:0];
          rsp.flags_out = pack_flags(r == 8'h00, 1'b0, nib[4], wide[8]);
        end
        ALU_AND: begin
          r = a & s;
          rsp.flags_out = pack_flags(r == 8'h00, 1'b0, 1'b1, 1'b0);
        end
        ALU_XOR: begin
          r = a ^ s;
          rsp.flags_out = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        ALU_OR: begin
          r = a | s;
          rsp.flags_out = pack_flags(r == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        default: begin
          // borrow shows up as the sign bit of the widened difference
          wide = {1'b0, a} - {1'b0, s} - {8'b0, c};
          nib = {1'b0, a[3:0]} - {1'b0, s[3:0]} - {4'b0, c};
          r = wide[7:0];
          rsp.flags_out = pack_flags(r == 8'h00, 1'b1, nib[4], wide[8]);
        end
      endcase
      rsp.result = r;
      if (op == ALU_CP) begin
        rsp.result = a;
        rsp.write_enable = 1'b0;
      end
    end else if ((q.opcode & GRP_MASK_ROW) == GRP_INC_R8) begin
      r = s + 8'h01;
      rsp.result = r;
      rsp.flags_out = pack_flags(r == 8'h00, 1'b0, s[3:0] == NIBBLE_MAX, cin);
    end else if ((q.opcode & GRP_MASK_ROW) == GRP_DEC_R8) begin
      r = s - 8'h01;
      rsp.result = r;
      rsp.flags_out = pack_flags(r == 8'h00, 1'b1, s[3:0] == 4'h0, cin);
    end else begin
      case (q.opcode)
        OPC_RLCA: begin
          rsp.result = {a[6:0], a[7]};
          rsp.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
        end
        OPC_RRCA: begin
          rsp.result = {a[0], a[7:1]};
          rsp.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
        end
        OPC_RLA: begin
          rsp.result = {a[6:0], cin};
          rsp.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[7]);
        end
        OPC_RRA: begin
          rsp.result = {cin, a[7:1]};
          rsp.flags_out = pack_flags(1'b0, 1'b0, 1'b0, a[0]);
        end
        OPC_DAA: begin
          r = a;
          c = cin;
          if (q.flags_in[FlagN]) begin
            if (c) r = r - DAA_ADJ_HI;
            if (q.flags_in[FlagH]) r = r - DAA_ADJ_LO;
          end else begin
            if (c || a > DAA_MAX_HI) begin
              r = r + DAA_ADJ_HI;
              c = 1'b1;
            end
            if (q.flags_in[FlagH] || a[3:0] > DAA_MAX_LO) r = r + DAA_ADJ_LO;
          end
          rsp.result = r;
          rsp.flags_out = pack_flags(r == 8'h00, q.flags_in[FlagN], 1'b0, c);
        end
        OPC_CPL: begin
          rsp.result = ~a;
          rsp.flags_out = pack_flags(q.flags_in[FlagZ], 1'b1, 1'b1, cin);
        end
        OPC_SCF: begin
          rsp.result = a;
          rsp.flags_out = pack_flags(q.flags_in[FlagZ], 1'b0, 1'b0, 1'b1);
        end
        OPC_CCF: begin
          rsp.result = a;
          rsp.flags_out = pack_flags(q.flags_in[FlagZ], 1'b0, 1'b0, ~cin);
        end
        default: begin
          rsp.write_enable = 1'b0;
          rsp.recognized = 1'b0;
        end
      endcase
    end
    return rsp;
  endfunction

  function automatic alu_req_t make_req(logic pre, logic [7:0] opc, logic [7:0] a,
                                        logic [7:0] s, logic [3:0] f);
    alu_req_t q;
    q.prefixed = pre;
    q.opcode = opc;
    q.acc_in = a;
    q.source_in = s;
    q.flags_in = f;
    return q;
  endfunction

  function automatic logic [7:0] alu_opc(alu_op_e op, logic imm);
    return imm ? (GRP_ALU_IMM | {2'b00, op, 3'b000}) : (GRP_ALU_REG | {2'b00, op, 3'b000});
  endfunction

  function automatic logic [7:0] cb_opc(cb_grp_e grp, logic [2:0] sel);
    return {grp, sel, 3'b000};
  endfunction

  // Bias toward nibble and byte boundaries a quarter of the time.
  function automatic logic [7:0] rand_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0: v = 8'h00;
        1: v = 8'hff;
        2: v = 8'h0f;
        3: v = 8'h10;
        4: v = 8'h7f;
        5: v = 8'h80;
        6: v = DAA_MAX_HI;
        default: v = DAA_MAX_HI + 8'h01;
      endcase
    end
    return v;
  endfunction

  function automatic alu_req_t rand_req();
    alu_req_t q;
    int       kind;
    logic [2:0] reg_sel;
    kind = $urandom_range(99);
    reg_sel = 3'($urandom);
    q = make_req(1'b0, 8'($urandom), rand_byte(), rand_byte(), 4'($urandom));
    if (kind < 30) begin
      if ($urandom_range(3) == 0) q.opcode = alu_opc(alu_op_e'(3'($urandom)), 1'b1);
      else q.opcode = alu_opc(alu_op_e'(3'($urandom)), 1'b0) | {5'b0, reg_sel};
    end else if (kind < 45) begin
      q.opcode = ($urandom_range(1) ? GRP_INC_R8 : GRP_DEC_R8) | {2'b00, reg_sel, 3'b000};
    end else if (kind < 60) begin
      case ($urandom_range(7))
        0: q.opcode = OPC_RLCA;
        1: q.opcode = OPC_RRCA;
        2: q.opcode = OPC_RLA;
        3: q.opcode = OPC_RRA;
        4: q.opcode = OPC_DAA;
        5: q.opcode = OPC_CPL;
        6: q.opcode = OPC_SCF;
        default: q.opcode = OPC_CCF;
      endcase
    end else if (kind < 85) begin
      q.prefixed = 1'b1;
    end else begin
      q.prefixed = 1'($urandom);
    end
    return q;
  endfunction

  // Offer one transaction and hold it until the block takes it.
  task automatic send_op(input alu_req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {prefixed, opcode, acc_in, source_in, flags_in} <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_op(make_req(1'b0, alu_opc(ALU_ADD, 1'b0), 8'hff, 8'h01, 4'h0));
    send_op(make_req(1'b0, alu_opc(ALU_ADC, 1'b0), 8'h0f, 8'h00, F_C));
    send_op(make_req(1'b0, alu_opc(ALU_SUB, 1'b0), 8'h5a, 8'h5a, 4'h0));
    send_op(make_req(1'b0, alu_opc(ALU_SBC, 1'b0), 8'h00, 8'hff, F_C));
    send_op(make_req(1'b0, alu_opc(ALU_CP, 1'b0), 8'h10, 8'h01, 4'h0));
    send_op(make_req(1'b0, alu_opc(ALU_AND, 1'b0), 8'hf0, 8'h0f, F_C));
    send_op(make_req(1'b0, alu_opc(ALU_XOR, 1'b0), 8'hff, 8'hff, 4'h0));
    send_op(make_req(1'b0, alu_opc(ALU_OR, 1'b0), 8'h00, 8'h00, F_Z | F_N | F_H | F_C));
    send_op(make_req(1'b0, alu_opc(ALU_ADD, 1'b1), 8'h7f, 8'h80, 4'h0));
    send_op(make_req(1'b0, GRP_INC_R8, 8'h00, 8'hff, F_C));
    send_op(make_req(1'b0, GRP_DEC_R8, 8'h00, 8'h00, 4'h0));
    send_op(make_req(1'b0, OPC_RLCA, 8'h80, 8'h00, F_Z));
    send_op(make_req(1'b0, OPC_RRCA, 8'h01, 8'h00, 4'h0));
    send_op(make_req(1'b0, OPC_RLA, 8'h80, 8'h00, 4'h0));
    send_op(make_req(1'b0, OPC_RRA, 8'h01, 8'h00, F_C));
    send_op(make_req(1'b0, OPC_DAA, 8'h9a, 8'h00, 4'h0));
    send_op(make_req(1'b0, OPC_DAA, 8'h00, 8'h00, F_N | F_H | F_C));
    send_op(make_req(1'b0, OPC_CPL, 8'h55, 8'h00, F_Z));
    send_op(make_req(1'b0, OPC_SCF, 8'h33, 8'h00, F_N | F_H));
    send_op(make_req(1'b0, OPC_CCF, 8'h33, 8'h00, F_C));
    send_op(make_req(1'b1, cb_opc(CB_SHIFT, SH_RL), 8'h00, 8'h80, F_C));
    send_op(make_req(1'b1, cb_opc(CB_SHIFT, SH_SWAP), 8'h00, 8'h00, F_C));
    send_op(make_req(1'b1, cb_opc(CB_BIT, 3'd7), 8'h00, 8'h7f, F_C));
    send_op(make_req(1'b1, cb_opc(CB_RES, 3'd0), 8'h00, 8'hff, F_N));
    send_op(make_req(1'b1, cb_opc(CB_SET, 3'd7), 8'h00, 8'h00, 4'h0));
    send_op(make_req(1'b0, OPC_NOP, 8'hff, 8'hff, F_Z | F_H));
  endtask

  task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (count) send_op(rand_req());
  endtask

  // Hold the output off while transactions keep coming, so the input side backs up.
  task automatic test_output_stall(input int count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles = 300;
    repeat (count) send_op(rand_req());
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    alu_rsp_t exp_rsp;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_alu({prefixed, opcode, acc_in, source_in, flags_in}));
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transaction: result %0h flags %0h", result, flags_out);
          err_cnt++;
        end else begin
          exp_rsp = expected_q.pop_front();
          if (result !== exp_rsp.result) begin
            $error("result: expected %0h, got %0h", exp_rsp.result, result);
            err_cnt++;
          end
          if (flags_out !== exp_rsp.flags_out) begin
            $error("flags_out: expected %0h, got %0h", exp_rsp.flags_out, flags_out);
            err_cnt++;
          end
          if (write_enable !== exp_rsp.write_enable) begin
            $error("write_enable: expected %0b, got %0b", exp_rsp.write_enable, write_enable);
            err_cnt++;
          end
          if (recognized !== exp_rsp.recognized) begin
            $error("recognized: expected %0b, got %0b", exp_rsp.recognized, recognized);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("eight_bit_cpu_alu_with_flags regression: fail");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_random_traffic(500, 38, 87);
    test_output_stall(40);
    wait_drained();
    test_random_traffic(500, 87, 38);
    test_random_traffic(585, 0, 0);
    wait_drained();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("eight_bit_cpu_alu_with_flags regression: pass");
    end else begin
      $display("eight_bit_cpu_alu_with_flags regression: fail");
    end
    $finish;
  end

endmodule
